// ===== rtl/conv3_pkg.sv =====
package conv3_pkg;

   // Geometry and arithmetic widths
   localparam int MAX_WIDTH     = 1024;
   localparam int ADDR_BITS     = $clog2(MAX_WIDTH);
   localparam int PIXEL_BITS    = 16;
   localparam int COEF_BITS     = 16;
   localparam int TAPS          = 3;
   localparam int COEF_ROW_BITS = 48;
   localparam int WIDTH_BITS    = 11;
   localparam int HEIGHT_BITS   = 16;
   localparam int OUT_BITS      = 35;
   localparam int PROD_BITS     = PIXEL_BITS + COEF_BITS;
   localparam int ROW_BITS      = PROD_BITS + 2;
   localparam int TOTAL_BITS    = ROW_BITS + 2;

   // Result queue
   localparam int QUEUE_DEPTH   = 8;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = QPTR_BITS + 1;

   // Register reset values
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1024);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(1024);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COEF_ROW_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_ROW_TOP    = 3'd0,
      CSR_COEF_ROW_MIDDLE = 3'd1,
      CSR_COEF_ROW_BOTTOM = 3'd2,
      CSR_IMAGE_WIDTH     = 3'd3,
      CSR_IMAGE_HEIGHT    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [PIXEL_BITS-1:0] pixel;
      logic                         start_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] filtered;
      logic                       last_of_frame;
   } rsp_payload_type;

endpackage

// ===== rtl/conv3x3_valid_filter.sv =====
// Datapath: an accepted pixel passes through the line memory read, the products, the row sums
// and the final sum into the result queue, and is taken from rsp_payload when rsp_stall is low.
// Throughput: one pixel per cycle while req_stall is low, set by the single line memory that is read
// and written back once per pixel; an 8-entry result queue absorbs rsp_stall.
// Reset (synchronous, active high) clears counters, window, queue, pipeline
// valids and registers to their defaults; the line memory is not cleared.
module conv3x3_valid_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  conv3_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output conv3_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [conv3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [conv3_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import conv3_pkg::*;

   // Configuration registers
   logic [COEF_ROW_BITS-1:0] coef_rows_ff [TAPS];
   logic [WIDTH_BITS-1:0]    image_width_ff;
   logic [HEIGHT_BITS-1:0]   image_height_ff;

   // Counters
   logic [ADDR_BITS-1:0]   col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;

   // Line memory: upper half newer row, lower half older row
   logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_BITS-1:0] mem_rd_ff;

   // Stage 1: memory data available
   logic                         s1_valid_ff;
   logic [ADDR_BITS-1:0]         s1_addr_ff;
   logic signed [PIXEL_BITS-1:0] s1_pixel_ff;
   logic                         s1_produce_ff;
   logic                         s1_last_ff;
   logic                         s1_fwd_ff;
   logic [PIXEL_BITS-1:0]        fwd_older_ff;
   logic [PIXEL_BITS-1:0]        fwd_newer_ff;

   // Window columns: [0..2] oldest column, [3..5] middle column, top to bottom
   logic [PIXEL_BITS-1:0] window_ff [6];

   // Stage 2: products
   logic                        s2_valid_ff;
   logic                        s2_produce_ff;
   logic                        s2_last_ff;
   logic signed [PROD_BITS-1:0] prod_in [TAPS][TAPS];
   logic signed [PROD_BITS-1:0] prod_ff [TAPS][TAPS];

   // Stage 3: row sums
   logic                       s3_valid_ff;
   logic                       s3_produce_ff;
   logic                       s3_last_ff;
   logic signed [ROW_BITS-1:0] row_sum_in [TAPS];
   logic signed [ROW_BITS-1:0] row_sum_ff [TAPS];

   // Result queue
   rsp_payload_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic [QCNT_BITS-1:0]   occupancy;
   logic signed [TOTAL_BITS-1:0] total_sum;
   logic                   push, pop;

   // Accept-time signals
   logic                   accept;
   logic [WIDTH_BITS-1:0]  width_eff;
   logic [ADDR_BITS-1:0]   col_now;
   logic [HEIGHT_BITS-1:0] row_now;
   logic [WIDTH_BITS-1:0]  col_ext;
   logic [WIDTH_BITS-1:0]  col_next;
   logic [HEIGHT_BITS:0]   row_next;
   logic                   produce_now;
   logic                   last_now;
   logic                   fwd_now;

   // Stage 1 window taps
   logic [PIXEL_BITS-1:0] cur_older, cur_newer;
   logic [PIXEL_BITS-1:0] tap_pix [TAPS][TAPS];

   assign csr_ready = 1'b1;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < TAPS; r++) begin
            coef_rows_ff[r] <= '0;
         end
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COEF_ROW_TOP:    coef_rows_ff[0] <= csr_data[COEF_ROW_BITS-1:0];
            CSR_COEF_ROW_MIDDLE: coef_rows_ff[1] <= csr_data[COEF_ROW_BITS-1:0];
            CSR_COEF_ROW_BOTTOM: coef_rows_ff[2] <= csr_data[COEF_ROW_BITS-1:0];
            CSR_IMAGE_WIDTH:     image_width_ff  <= csr_data[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT:    image_height_ff <= csr_data[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Admit a pixel only while the queue can take every pixel in flight
   assign occupancy = count_ff + QCNT_BITS'(s1_valid_ff) + QCNT_BITS'(s2_valid_ff)
                    + QCNT_BITS'(s3_valid_ff);
   assign req_stall = (occupancy >= QCNT_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Position of the incoming pixel and its result flags
   always_comb begin
      width_eff = (image_width_ff > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
                                                            : image_width_ff;
      col_now   = req_payload.start_of_frame ? '0 : col_ff;
      row_now   = req_payload.start_of_frame ? '0 : row_ff;
      col_ext   = WIDTH_BITS'(col_now);
      produce_now = (width_eff >= WIDTH_BITS'(3)) && (image_height_ff >= HEIGHT_BITS'(3))
                 && (col_ext >= WIDTH_BITS'(2)) && (row_now >= HEIGHT_BITS'(2))
                 && (col_ext < width_eff) && (row_now < image_height_ff);
      last_now  = (row_now == image_height_ff - HEIGHT_BITS'(1))
               && (col_ext == width_eff - WIDTH_BITS'(1));
      col_next  = col_ext + WIDTH_BITS'(1);
      row_next  = {1'b0, row_now} + (HEIGHT_BITS+1)'(1);
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, image_height_ff}) ? '0 : row_next[HEIGHT_BITS-1:0];
         end else begin
            col_in = col_next[ADDR_BITS-1:0];
            row_in = row_now;
         end
      end
      // Write-back of stage 1 lands at the same edge as this read
      fwd_now = s1_valid_ff && (s1_addr_ff == col_now);
   end

   // Advance counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Read and write back the line memory
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= {s1_pixel_ff, cur_newer};
      end
      if (accept) begin
         mem_rd_ff <= line_mem[col_now];
      end
   end

   // Stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff    <= col_now;
         s1_pixel_ff   <= req_payload.pixel;
         s1_produce_ff <= produce_now;
         s1_last_ff    <= last_now;
         s1_fwd_ff     <= fwd_now;
         fwd_older_ff  <= cur_newer;
         fwd_newer_ff  <= s1_pixel_ff;
      end
   end

   // Pick forwarded rows over stale memory data, then form the 3x3 taps
   always_comb begin
      cur_older = s1_fwd_ff ? fwd_older_ff : mem_rd_ff[PIXEL_BITS-1:0];
      cur_newer = s1_fwd_ff ? fwd_newer_ff : mem_rd_ff[2*PIXEL_BITS-1:PIXEL_BITS];
      tap_pix[0][0] = window_ff[0];
      tap_pix[1][0] = window_ff[1];
      tap_pix[2][0] = window_ff[2];
      tap_pix[0][1] = window_ff[3];
      tap_pix[1][1] = window_ff[4];
      tap_pix[2][1] = window_ff[5];
      tap_pix[0][2] = cur_older;
      tap_pix[1][2] = cur_newer;
      tap_pix[2][2] = s1_pixel_ff;
      for (int r = 0; r < TAPS; r++) begin
         for (int c = 0; c < TAPS; c++) begin
            prod_in[r][c] = PROD_BITS'($signed(tap_pix[r][c])
                          * $signed(coef_rows_ff[r][c*COEF_BITS +: COEF_BITS]));
         end
      end
   end

   // Shift the window by one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         window_ff[0] <= window_ff[3];
         window_ff[1] <= window_ff[4];
         window_ff[2] <= window_ff[5];
         window_ff[3] <= cur_older;
         window_ff[4] <= cur_newer;
         window_ff[5] <= s1_pixel_ff;
      end
   end

   // Stage 2 and 3 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Sum each kernel row
   always_comb begin
      for (int r = 0; r < TAPS; r++) begin
         row_sum_in[r] = ROW_BITS'(prod_ff[r][0]) + ROW_BITS'(prod_ff[r][1])
                       + ROW_BITS'(prod_ff[r][2]);
      end
   end

   // Stage 2 and 3 payload
   always_ff @(posedge clock) begin
      s2_produce_ff <= s1_produce_ff;
      s2_last_ff    <= s1_last_ff;
      s3_produce_ff <= s2_produce_ff;
      s3_last_ff    <= s2_last_ff;
      prod_ff       <= prod_in;
      row_sum_ff    <= row_sum_in;
   end

   // Final sum into the result queue
   assign total_sum = TOTAL_BITS'(row_sum_ff[0]) + TOTAL_BITS'(row_sum_ff[1])
                    + TOTAL_BITS'(row_sum_ff[2]);
   assign push      = s3_valid_ff && s3_produce_ff;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].filtered      <= total_sum[OUT_BITS-1:0];
         queue_ff[wr_ptr_ff].last_of_frame <= s3_last_ff;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = queue_ff[rd_ptr_ff];

endmodule

// ===== verif/conv3x3_valid_filter_tb.sv =====
`timescale 1ns / 100ps

module conv3x3_valid_filter_tb;
   import conv3_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 12;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int RANDOM_PIXELS  = 400;
   localparam int MAX_REPORTS    = 100;

   localparam logic [PIXEL_BITS-1:0]    MOST_NEG_PIXEL = 16'h8000;
   localparam logic [PIXEL_BITS-1:0]    MOST_POS_PIXEL = 16'h7FFF;
   localparam logic [COEF_ROW_BITS-1:0] MOST_NEG_ROW   = {TAPS{16'h8000}};
   localparam logic [COEF_ROW_BITS-1:0] MOST_POS_ROW   = {TAPS{16'h7FFF}};

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data    = '0;

   // Shadow copy of the filter: registers, line rows, window and counters
   logic [COEF_ROW_BITS-1:0]     coef_rows_q [TAPS];
   logic [WIDTH_BITS-1:0]        width_q;
   logic [HEIGHT_BITS-1:0]       height_q;
   logic signed [PIXEL_BITS-1:0] older_row [MAX_WIDTH];
   logic signed [PIXEL_BITS-1:0] newer_row [MAX_WIDTH];
   logic signed [PIXEL_BITS-1:0] window_q [2*TAPS];
   int unsigned                  col_q;
   int unsigned                  row_q;

   rsp_payload_type expected_sums [$];
   req_payload_type pending_pixels [$];

   int pixels_queued    = 0;
   int pixels_accepted  = 0;
   int frame_marks      = 0;
   int results_checked  = 0;
   int error_count      = 0;
   int req_idle_pct     = 33;
   int rsp_idle_pct     = 33;
   int holdoff_requests = 0;
   int holdoff_served   = 0;
   int holdoff_left     = 0;
   int cycle_count      = 0;

   conv3x3_valid_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      // keep the log readable when something is badly broken
      if (error_count <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   task automatic clear_filter_state();
      for (int t = 0; t < TAPS; t++) begin
         coef_rows_q[t] = '0;
      end
      width_q  = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (int k = 0; k < 2*TAPS; k++) begin
         window_q[k] = '0;
      end
      col_q = 0;
      row_q = 0;
   endtask

   // Advance the shadow filter by one pixel; queue the sum if the window is inside
   task automatic convolve_pixel(input req_payload_type item);
      int unsigned                    w, h, col, row, idx;
      logic signed [PIXEL_BITS-1:0]   cur [TAPS];
      logic signed [PIXEL_BITS-1:0]   tap;
      logic signed [COEF_BITS-1:0]    coef;
      logic signed [PROD_BITS-1:0]    prod;
      logic signed [63:0]             sum;
      rsp_payload_type                res;
      w = (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
      h = height_q;
      if (item.start_of_frame) begin
         col_q = 0;
         row_q = 0;
      end
      col = col_q;
      row = row_q;
      idx = col % MAX_WIDTH;
      cur[0] = older_row[idx];
      cur[1] = newer_row[idx];
      cur[2] = item.pixel;

      if (w >= 3 && h >= 3 && col >= 2 && row >= 2 && col < w && row < h) begin
         sum = '0;
         for (int r = 0; r < TAPS; r++) begin
            for (int c = 0; c < TAPS; c++) begin
               tap  = (c == 0) ? window_q[r] : (c == 1) ? window_q[TAPS + r] : cur[r];
               coef = coef_rows_q[r][c*COEF_BITS +: COEF_BITS];
               prod = tap * coef;
               sum  = sum + prod;
            end
         end
         res.filtered      = sum[OUT_BITS-1:0];
         res.last_of_frame = (row == h - 1) && (col == w - 1);
         expected_sums.push_back(res);
      end

      // shift line rows and the window
      older_row[idx] = cur[1];
      newer_row[idx] = item.pixel;
      for (int k = 0; k < TAPS; k++) begin
         window_q[k]        = window_q[TAPS + k];
         window_q[TAPS + k] = cur[k];
      end

      // wrap at end of row and frame
      if (col + 1 >= w) begin
         col_q = 0;
         row_q = (row + 1 >= h) ? 0 : ((row + 1) & 32'hFFFF);
      end else begin
         col_q = col + 1;
      end
   endtask

   // Pixel driver: offer the next pending pixel, hold it while stalled
   always @(posedge clock) begin : pixel_driver
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            convolve_pixel(req_payload);
            pixels_accepted++;
            offer = 1'b0;
         end
         if (!offer && pending_pixels.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_payload <= pending_pixels.pop_front();
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // Result monitor: compare each transaction with the oldest expected sum
   always @(posedge clock) begin : result_monitor
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_sums.size() == 0) begin
               report_mismatch($sformatf("unexpected result filtered=%0d last=%0b",
                                         rsp_payload.filtered, rsp_payload.last_of_frame));
            end else begin
               want = expected_sums.pop_front();
               if (rsp_payload.filtered !== want.filtered) begin
                  report_mismatch($sformatf("filtered got %0d want %0d",
                                            rsp_payload.filtered, want.filtered));
               end
               if (rsp_payload.last_of_frame !== want.last_of_frame) begin
                  report_mismatch($sformatf("last_of_frame got %0b want %0b",
                                            rsp_payload.last_of_frame, want.last_of_frame));
               end
            end
         end
      end
      rsp_stall <= (holdoff_left != 0) || ($urandom_range(99) < rsp_idle_pct);
   end

   // Long receiver hold-off, counted here, started on request from the stimulus
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (holdoff_served != holdoff_requests) begin
         holdoff_left   <= HOLDOFF_CYCLES;
         holdoff_served <= holdoff_requests;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("conv3x3_valid_filter_tb: errors");
         $finish;
      end
   end

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_COEF_ROW_TOP, CSR_COEF_ROW_MIDDLE, CSR_COEF_ROW_BOTTOM: begin
            coef_rows_q[int'(index)] = value[COEF_ROW_BITS-1:0];
         end
         CSR_IMAGE_WIDTH: begin
            width_q = value[WIDTH_BITS-1:0];
         end
         CSR_IMAGE_HEIGHT: begin
            height_q = value[HEIGHT_BITS-1:0];
         end
         default: ;
      endcase
   endtask

   task automatic set_coefs(input logic [COEF_ROW_BITS-1:0] top,
                            input logic [COEF_ROW_BITS-1:0] middle,
                            input logic [COEF_ROW_BITS-1:0] bottom);
      write_register(CSR_COEF_ROW_TOP, CSR_DATA_BITS'(top));
      write_register(CSR_COEF_ROW_MIDDLE, CSR_DATA_BITS'(middle));
      write_register(CSR_COEF_ROW_BOTTOM, CSR_DATA_BITS'(bottom));
   endtask

   task automatic set_geometry(input int cols, input int rows);
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(cols));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(rows));
   endtask

   task automatic queue_pixel(input logic [PIXEL_BITS-1:0] value, input logic sof);
      req_payload_type item;
      item.pixel          = value;
      item.start_of_frame = sof;
      pending_pixels.push_back(item);
      pixels_queued++;
      if (sof) begin
         frame_marks++;
      end
   endtask

   function automatic logic [PIXEL_BITS-1:0] any_pixel();
      case ($urandom_range(7))
         0:       return MOST_NEG_PIXEL;
         1:       return MOST_POS_PIXEL;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [COEF_ROW_BITS-1:0] any_coef_row();
      logic [COEF_ROW_BITS-1:0] row;
      for (int c = 0; c < TAPS; c++) begin
         case ($urandom_range(9))
            0:       row[c*COEF_BITS +: COEF_BITS] = 16'h8000;
            1:       row[c*COEF_BITS +: COEF_BITS] = 16'h7FFF;
            2:       row[c*COEF_BITS +: COEF_BITS] = '0;
            default: row[c*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom);
         endcase
      end
      return row;
   endfunction

   // Random pixels; the first carries the given frame mark, the rest a stray one now and then
   task automatic queue_run(input int count, input logic first_sof, input int stray_pct);
      for (int i = 0; i < count; i++) begin
         queue_pixel(any_pixel(), (i == 0) ? first_sof : ($urandom_range(99) < stray_pct));
      end
   endtask

   // Wait until every pixel is in and every sum is out, then let the pipeline settle
   task automatic wait_for_drain();
      do @(posedge clock);
      while (pixels_accepted != pixels_queued || expected_sums.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int w, h, nframes, count, random_floor, phase;
      clear_filter_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Largest sums of both signs, then a second frame that starts by wrapping
      set_coefs(MOST_NEG_ROW, MOST_NEG_ROW, MOST_NEG_ROW);
      set_geometry(3, 3);
      for (int i = 0; i < 9; i++) queue_pixel(MOST_NEG_PIXEL, i == 0);
      for (int i = 0; i < 9; i++) queue_pixel(MOST_POS_PIXEL, 1'b0);
      wait_for_drain();

      // Frames too narrow or too short: no results
      set_geometry(2, 3);
      queue_run(4, 1'b1, 0);
      wait_for_drain();
      set_geometry(0, 3);
      queue_run(2, 1'b1, 0);
      wait_for_drain();
      set_geometry(3, 0);
      queue_run(3, 1'b1, 0);
      wait_for_drain();

      // Shrink the width while the column counter sits past the new limit
      set_coefs(MOST_POS_ROW, {16'h8000, 16'h0001, 16'hFFFF}, MOST_NEG_ROW);
      set_geometry(4, 4);
      queue_run(11, 1'b1, 0);
      wait_for_drain();
      set_geometry(3, 4);
      queue_run(4, 1'b0, 0);
      wait_for_drain();

      // Oversized width saturates: the row wraps after the full line store
      set_coefs(any_coef_row(), any_coef_row(), any_coef_row());
      set_geometry(2047, 3);
      queue_run(2 * MAX_WIDTH + 3, 1'b1, 0);
      wait_for_drain();

      // Tallest frame, cut short
      set_geometry(3, 65535);
      queue_run(12, 1'b1, 0);
      wait_for_drain();

      // Random phases: new coefficients and geometry each time
      random_floor = pixels_queued;
      phase = 0;
      while (pixels_queued - random_floor < RANDOM_PIXELS) begin
         set_coefs(any_coef_row(), any_coef_row(), any_coef_row());
         req_idle_pct = 33;
         rsp_idle_pct = 33;
         if (phase == 0) begin
            // long stretch with no idling on either side
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            set_geometry(8, 12);
            queue_run(2 * 8 * 12, 1'b1, 0);
         end else if (phase == 1) begin
            // back up the output while the sender keeps going
            req_idle_pct = 0;
            set_geometry(3, 60);
            queue_run(180, 1'b1, 0);
            holdoff_requests <= holdoff_requests + 1;
         end else begin
            case ($urandom_range(9))
               0: begin
                  w = $urandom_range(0, 2);
                  h = $urandom_range(1, 6);
               end
               1: begin
                  w = $urandom_range(3, 10);
                  h = $urandom_range(0, 2);
               end
               2: begin
                  w = $urandom_range(11, 40);
                  h = $urandom_range(3, 5);
               end
               default: begin
                  w = $urandom_range(3, 10);
                  h = $urandom_range(3, 8);
               end
            endcase
            set_geometry(w, h);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
               count = ((w == 0) ? 3 : w) * ((h == 0) ? 3 : h);
               case ($urandom_range(4))
                  0:       queue_run($urandom_range(1, count), 1'b1, 0);
                  1:       queue_run(count, 1'b1, 3);
                  default: queue_run(count, (f == 0) || $urandom_range(1), 0);
               endcase
            end
         end
         wait_for_drain();
         phase++;
      end

      $display("Checked %0d filtered results from %0d pixels over %0d frame starts.",
               results_checked, pixels_accepted, frame_marks);
      $display("Ran extreme taps, tiny and saturated frames, a counter overrun and a full backup.");
      if (error_count == 0) begin
         $display("conv3x3_valid_filter_tb: clean");
      end else begin
         $display("conv3x3_valid_filter_tb: errors");
      end
      $finish;
   end

endmodule
